### sv/ima_pkg.sv
package ima_pkg;

  localparam int unsigned STEP_LAST = 88;
  localparam int unsigned IDX_W = 7;
  localparam int unsigned STEP_W = 15;
  localparam int unsigned DQ_W = 16;

  localparam logic signed [15:0] PRED_MAX = 16'sh7FFF;
  localparam logic signed [15:0] PRED_MIN = -16'sh8000;

  localparam logic [3:0] CODE_SIGN = 4'b1000;

  typedef logic [3:0] code_t;

  typedef struct packed {
    logic signed [15:0] pred;
    logic [IDX_W-1:0]   idx;
  } ima_state_t;

  localparam logic [STEP_W-1:0] STEP_SIZES [0:STEP_LAST] = '{
    15'd7,     15'd8,     15'd9,     15'd10,    15'd11,    15'd12,    15'd13,
    15'd14,    15'd16,    15'd17,    15'd19,    15'd21,    15'd23,    15'd25,
    15'd28,    15'd31,    15'd34,    15'd37,    15'd41,    15'd45,    15'd50,
    15'd55,    15'd60,    15'd66,    15'd73,    15'd80,    15'd88,    15'd97,
    15'd107,   15'd118,   15'd130,   15'd143,   15'd157,   15'd173,   15'd190,
    15'd209,   15'd230,   15'd253,   15'd279,   15'd307,   15'd337,   15'd371,
    15'd408,   15'd449,   15'd494,   15'd544,   15'd598,   15'd658,   15'd724,
    15'd796,   15'd876,   15'd963,   15'd1060,  15'd1166,  15'd1282,  15'd1411,
    15'd1552,  15'd1707,  15'd1878,  15'd2066,  15'd2272,  15'd2499,  15'd2749,
    15'd3024,  15'd3327,  15'd3660,  15'd4026,  15'd4428,  15'd4871,  15'd5358,
    15'd5894,  15'd6484,  15'd7132,  15'd7845,  15'd8630,  15'd9493,  15'd10442,
    15'd11487, 15'd12635, 15'd13899, 15'd15289, 15'd16818, 15'd18500, 15'd20350,
    15'd22385, 15'd24623, 15'd27086, 15'd29794, 15'd32767
  };

  function automatic logic [IDX_W-1:0] clamp_idx(input logic [IDX_W-1:0] idx);
    if (idx > IDX_W'(STEP_LAST)) begin
      return IDX_W'(STEP_LAST);
    end
    return idx;
  endfunction

  function automatic logic [STEP_W-1:0] step_size(input logic [IDX_W-1:0] idx);
    return STEP_SIZES[clamp_idx(idx)];
  endfunction

  function automatic logic signed [4:0] index_move(input logic [2:0] mag);
    case (mag)
      3'd4:    return 5'sd2;
      3'd5:    return 5'sd4;
      3'd6:    return 5'sd6;
      3'd7:    return 5'sd8;
      default: return -5'sd1;
    endcase
  endfunction

endpackage

### sv/ima_if.sv
interface ima_in_if;
  logic        valid;
  logic        ready;
  logic        restart;
  logic [15:0] pcm_sample;
  logic [3:0]  code_in;

  modport source (output valid, output restart, output pcm_sample, output code_in,
                  input ready);
  modport sink (input valid, input restart, input pcm_sample, input code_in,
                output ready);
endinterface

interface ima_out_if;
  logic        valid;
  logic        ready;
  logic [3:0]  code_out;
  logic [15:0] recon_sample;

  modport source (output valid, output code_out, output recon_sample, input ready);
  modport sink (input valid, input code_out, input recon_sample, output ready);
endinterface

interface ima_cfg_if;
  logic valid;
  logic ready;
  logic direction;

  modport source (output valid, output direction, input ready);
  modport sink (input valid, input direction, output ready);
endinterface

### sv/ima_quant.sv
module ima_quant (
  input  ima_pkg::ima_state_t cur,
  input  logic signed [15:0]  sample,
  output ima_pkg::code_t      code
);
  import ima_pkg::*;

  logic [STEP_W-1:0]  step;
  logic signed [16:0] diff;
  logic [16:0]        mag0;
  logic [16:0]        mag1;
  logic [16:0]        mag2;
  logic               b2;
  logic               b1;
  logic               b0;

  always_comb begin
    step = step_size(cur.idx);
    diff = 17'(sample) - 17'(cur.pred);
    mag0 = diff[16] ? 17'(-diff) : 17'(diff);
    b2   = mag0 >= 17'(step);
    mag1 = b2 ? mag0 - 17'(step) : mag0;
    b1   = mag1 >= 17'(step >> 1);
    mag2 = b1 ? mag1 - 17'(step >> 1) : mag1;
    b0   = mag2 >= 17'(step >> 2);
    code = {diff[16], b2, b1, b0};
  end

endmodule

### sv/ima_update.sv
module ima_update (
  input  ima_pkg::ima_state_t cur,
  input  ima_pkg::code_t      code,
  output ima_pkg::ima_state_t nxt
);
  import ima_pkg::*;

  logic [STEP_W-1:0]  step;
  logic [DQ_W-1:0]    dq;
  logic signed [17:0] sum;
  logic signed [7:0]  idx_sum;

  always_comb begin
    step = step_size(cur.idx);
    dq   = DQ_W'(step >> 3);
    if (code[2]) begin
      dq = dq + DQ_W'(step);
    end
    if (code[1]) begin
      dq = dq + DQ_W'(step >> 1);
    end
    if (code[0]) begin
      dq = dq + DQ_W'(step >> 2);
    end

    if ((code & CODE_SIGN) != 4'd0) begin
      sum = 18'(cur.pred) - $signed({2'b00, dq});
    end else begin
      sum = 18'(cur.pred) + $signed({2'b00, dq});
    end

    if (sum > 18'(PRED_MAX)) begin
      nxt.pred = PRED_MAX;
    end else if (sum < 18'(PRED_MIN)) begin
      nxt.pred = PRED_MIN;
    end else begin
      nxt.pred = sum[15:0];
    end

    idx_sum = $signed({1'b0, clamp_idx(cur.idx)}) + 8'(index_move(code[2:0]));
    if (idx_sum < 8'sd0) begin
      nxt.idx = '0;
    end else if (idx_sum > 8'(STEP_LAST)) begin
      nxt.idx = IDX_W'(STEP_LAST);
    end else begin
      nxt.idx = idx_sum[IDX_W-1:0];
    end
  end

endmodule

### sv/ima_adpcm_codec.sv
// IMA ADPCM codec, one sample per item.
// Path: the input register loads at accept; the result register loads when the item advances.
// Throughput: 1 item per cycle unless the output stalls; quantizer and update are combinational.
// The result register decouples the sides; a stalled output holds the input register.
// Reset (rst, synchronous): clears predictor, step index, direction and all valid flags.
module ima_adpcm_codec (
  input  logic              clk,
  input  logic              rst,
  ima_cfg_if.sink           cfg,
  ima_in_if.sink            din,
  ima_out_if.source         dout
);
  import ima_pkg::*;

  logic               direction;
  logic               in_valid;
  logic               in_restart;
  logic signed [15:0] in_pcm;
  code_t              in_code;
  logic               out_valid;
  code_t              out_code;
  logic signed [15:0] out_recon;
  ima_state_t         state;
  ima_state_t         cur;
  ima_state_t         state_next;
  code_t              qcode;
  code_t              code;
  logic               advance;

  assign advance   = in_valid && (!out_valid || dout.ready);
  assign din.ready = !in_valid || advance;
  assign cfg.ready = 1'b1;

  assign cur  = in_restart ? '0 : state;
  assign code = direction ? in_code : qcode;

  ima_quant u_quant (
    .cur    (cur),
    .sample (in_pcm),
    .code   (qcode)
  );

  ima_update u_update (
    .cur  (cur),
    .code (code),
    .nxt  (state_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      direction <= 1'b0;
      in_valid  <= 1'b0;
      out_valid <= 1'b0;
      state     <= '0;
    end else begin
      if (cfg.valid && cfg.ready) begin
        direction <= cfg.direction;
      end
      if (din.ready) begin
        in_valid <= din.valid;
      end
      if (!out_valid || dout.ready) begin
        out_valid <= in_valid;
      end
      if (advance) begin
        state <= state_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (din.valid && din.ready) begin
      in_restart <= din.restart;
      in_pcm     <= din.pcm_sample;
      in_code    <= din.code_in;
    end
    if (advance) begin
      out_code  <= code;
      out_recon <= state_next.pred;
    end
  end

  assign dout.valid        = out_valid;
  assign dout.code_out     = out_code;
  assign dout.recon_sample = out_recon;

`ifndef NO_ASSERTIONS
  a_idx_range: assert property (@(posedge clk) disable iff (rst)
    state.idx <= IDX_W'(STEP_LAST))
    else $error("step index above table end");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !dout.ready) |=> ($stable(state) && $stable(out_recon)))
    else $error("state moved while result stalled");

  a_decode_copy: assert property (@(posedge clk) disable iff (rst)
    (advance && direction) |=> (out_code == $past(in_code)))
    else $error("decode result code differs from input code");

  a_recon_state: assert property (@(posedge clk) disable iff (rst)
    $past(advance) |-> (out_recon == state.pred))
    else $error("result sample differs from predictor");
`endif

endmodule
